[rtl/wpss_pkg.sv]
`default_nettype none

package wpss_pkg;

  // Item kinds carried on the input channel
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_DEAD_BAND    = 3'd3,
    CFG_CONTROL_MAX  = 3'd4,
    CFG_CONTROL_STEP = 3'd5,
    CFG_RANGE_LIMIT  = 3'd6
  } cfg_idx_t;

  localparam int CFG_DATA_W = 32;

  // Field widths
  localparam int GAIN_W = 16;
  localparam int DIST_W = 16;
  localparam int ERR_W  = 17;
  localparam int BAND_W = 31;
  localparam int CTRL_W = 15;
  localparam int STEER_W = 16;
  localparam int COMB_W = 32;

  // Window depth default
  localparam int WINDOW_DEPTH_DEF = 16;

  // Register reset values
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST      = 16'sd256;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST      = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST      = 16'sd0;
  localparam logic [BAND_W-1:0]        DEAD_BAND_RST   = 31'd0;
  localparam logic [CTRL_W-1:0]        CONTROL_MAX_RST = 15'd1000;
  localparam logic [CTRL_W-1:0]        CONTROL_STEP_RST = 15'd50;
  localparam logic [DIST_W-1:0]        RANGE_LIMIT_RST = 16'd30000;

  // Saturation bounds for the combined error
  localparam logic signed [63:0] COMB_HI = 64'sd2147483647;
  localparam logic signed [63:0] COMB_LO = -64'sd2147483648;

endpackage

`default_nettype wire

[rtl/windowed_pid_step_steering.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    opcode, distances, invalid/infinite flags
// out_      output     out_valid / out_ready  steer_control, combined_error
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while no stage is stalled. A tick's result moves from the
// input register through products, then sum/scale/saturate, then the control step.
// A sample shifts the error window straight from the input register; no result.
// Reset (rst_n low, synchronous) clears window, sum and control state and
// restores the register defaults. Stages hold while the next one is stalled;
// a tick waits in the input register only then. cfg_ready is always high.

module windowed_pid_step_steering #(
  parameter int WINDOW_DEPTH = wpss_pkg::WINDOW_DEPTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_opcode,
  input  wire [wpss_pkg::DIST_W-1:0]        in_left_mm,
  input  wire [wpss_pkg::DIST_W-1:0]        in_right_mm,
  input  wire                               in_left_invalid,
  input  wire                               in_left_infinite,
  input  wire                               in_right_invalid,
  input  wire                               in_right_infinite,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [wpss_pkg::STEER_W-1:0] out_steer_control,
  output logic signed [wpss_pkg::COMB_W-1:0]  out_combined_error,
  // configuration channel
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [wpss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [wpss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import wpss_pkg::*;

  localparam int SUM_W = ERR_W + $clog2(WINDOW_DEPTH);
  localparam int PP_W  = GAIN_W + ERR_W;
  localparam int PI_W  = GAIN_W + SUM_W;
  localparam int PD_W  = GAIN_W + ERR_W + 1;
  localparam int ACC_W = PI_W + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [BAND_W-1:0]        dead_band_r;
  logic [CTRL_W-1:0]        control_max_r, control_step_r;
  logic [DIST_W-1:0]        range_limit_r;
  cfg_idx_t                 cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r       <= GAIN_P_RST;
      gain_i_r       <= GAIN_I_RST;
      gain_d_r       <= GAIN_D_RST;
      dead_band_r    <= DEAD_BAND_RST;
      control_max_r  <= CONTROL_MAX_RST;
      control_step_r <= CONTROL_STEP_RST;
      range_limit_r  <= RANGE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_sel)
        CFG_GAIN_P:       gain_p_r       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:       gain_i_r       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:       gain_d_r       <= cfg_data[GAIN_W-1:0];
        CFG_DEAD_BAND:    dead_band_r    <= cfg_data[BAND_W-1:0];
        CFG_CONTROL_MAX:  control_max_r  <= cfg_data[CTRL_W-1:0];
        CFG_CONTROL_STEP: control_step_r <= cfg_data[CTRL_W-1:0];
        CFG_RANGE_LIMIT:  range_limit_r  <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshakes (each stage drains when the next has room)
  logic    s1_v_r, s2_v_r, s3_v_r, out_v_r;
  opcode_t s1_op_r;
  logic    out_go, s3_go, s2_go, s1_go;

  assign out_go   = !out_v_r || out_ready;
  assign s3_go    = s3_v_r && out_go;
  assign s2_go    = s2_v_r && (!s3_v_r || out_go);
  assign s1_go    = s1_v_r && ((s1_op_r == OP_SAMPLE) || !s2_v_r || s3_go || !s3_v_r);
  assign in_ready = !s1_v_r || s1_go;

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  logic [DIST_W-1:0] s1_left_r, s1_right_r;
  logic              s1_linv_r, s1_linf_r, s1_rinv_r, s1_rinf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= opcode_t'(in_opcode);
      s1_left_r  <= in_left_mm;
      s1_right_r <= in_right_mm;
      s1_linv_r  <= in_left_invalid;
      s1_linf_r  <= in_left_infinite;
      s1_rinv_r  <= in_right_invalid;
      s1_rinf_r  <= in_right_infinite;
    end
  end

  // ---------------------------------------------------------------------------
  // Error window and running sum (shift line, taps at fixed places)
  logic signed [ERR_W-1:0] win_r [WINDOW_DEPTH];
  logic signed [SUM_W-1:0] win_sum_r, win_sum_nxt;
  logic [DIST_W-1:0]       left_eff, right_eff;
  logic signed [ERR_W-1:0] err_new;
  logic                    push;

  assign left_eff  = s1_linf_r ? range_limit_r : s1_left_r;
  assign right_eff = s1_rinf_r ? range_limit_r : s1_right_r;
  assign err_new   = $signed({1'b0, left_eff}) - $signed({1'b0, right_eff});
  assign push      = s1_go && (s1_op_r == OP_SAMPLE) && !s1_linv_r && !s1_rinv_r;

  // wraps in SUM_W bits; the true sum of the window always fits
  assign win_sum_nxt = win_sum_r + SUM_W'(err_new) - SUM_W'(win_r[WINDOW_DEPTH-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      win_sum_r <= '0;
    end else if (push) begin
      win_r[0] <= err_new;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
      win_sum_r <= win_sum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the three gain products
  logic signed [ERR_W:0]   err_diff;
  logic signed [PP_W-1:0]  prod_p, s2_pp_r;
  logic signed [PI_W-1:0]  prod_i, s2_pi_r;
  logic signed [PD_W-1:0]  prod_d, s2_pd_r;
  logic                    tick_go;

  assign tick_go  = s1_go && (s1_op_r == OP_TICK);
  assign err_diff = (ERR_W+1)'(win_r[0]) - (ERR_W+1)'(win_r[1]);
  assign prod_p   = PP_W'(gain_p_r) * PP_W'(win_r[0]);
  assign prod_i   = PI_W'(gain_i_r) * PI_W'(win_sum_r);
  assign prod_d   = PD_W'(gain_d_r) * PD_W'(err_diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!s2_v_r || s2_go) begin
      s2_v_r <= tick_go;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      s2_pp_r <= prod_p;
      s2_pi_r <= prod_i;
      s2_pd_r <= prod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum, floor scale by 256, saturate to 32 bits
  logic signed [ACC_W-1:0]  acc, acc_sh;
  logic signed [63:0]       acc_ext;
  logic signed [COMB_W-1:0] comb_nxt, s3_comb_r;

  assign acc     = ACC_W'(s2_pp_r) + ACC_W'(s2_pi_r) + ACC_W'(s2_pd_r);
  assign acc_sh  = acc >>> 8;
  assign acc_ext = 64'(acc_sh);

  always_comb begin
    if (acc_ext > COMB_HI) begin
      comb_nxt = COMB_HI[COMB_W-1:0];
    end else if (acc_ext < COMB_LO) begin
      comb_nxt = COMB_LO[COMB_W-1:0];
    end else begin
      comb_nxt = acc_ext[COMB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (!s3_v_r || out_go) begin
      s3_v_r <= s2_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_comb_r <= comb_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: control step decision, steering state and output register
  logic signed [STEER_W-1:0] steer_r, steer_nxt;
  logic signed [COMB_W-1:0]  last_comb_r;
  logic signed [STEER_W+1:0] cur_s, cmax_s, step_s, new_s;
  logic signed [COMB_W:0]    c_ext, band_ext;
  logic                      err_pos, err_neg;

  assign cur_s    = (STEER_W+2)'(steer_r);
  assign cmax_s   = $signed({3'b000, control_max_r});
  assign step_s   = $signed({3'b000, control_step_r});
  assign c_ext    = (COMB_W+1)'(s3_comb_r);
  assign band_ext = $signed({2'b00, dead_band_r});
  assign err_pos  = c_ext > band_ext;
  assign err_neg  = c_ext < -band_ext;

  always_comb begin
    new_s = cur_s;
    if (err_pos && (cur_s < cmax_s)) begin
      // step up, or restart from zero on a sign change
      new_s = (last_comb_r < 0) ? '0 : cur_s + step_s;
    end else if (err_neg && (cur_s > -cmax_s)) begin
      new_s = (last_comb_r > 0) ? '0 : cur_s - step_s;
    end else if (!err_pos && !err_neg) begin
      // inside the deadband
      new_s = '0;
    end
    // clamp to the present limit
    if (new_s > cmax_s) begin
      new_s = cmax_s;
    end else if (new_s < -cmax_s) begin
      new_s = -cmax_s;
    end
    steer_nxt = new_s[STEER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      steer_r     <= '0;
      last_comb_r <= '0;
    end else if (s3_go) begin
      out_v_r     <= 1'b1;
      steer_r     <= steer_nxt;
      last_comb_r <= s3_comb_r;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_steer_control  <= steer_nxt;
      out_combined_error <= s3_comb_r;
    end
  end

  assign out_valid = out_v_r;

  // ---------------------------------------------------------------------------
  // Checks
  a_steer_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (steer_r <= $signed({1'b0, control_max_r}))
             && (steer_r >= -$signed({1'b0, control_max_r})))
    else $error("steering control outside +/- control_max");

  a_tick_enters_products: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> s2_v_r)
    else $error("tick lost between input and product stage");

  a_dropped_sample_keeps_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_op_r == OP_SAMPLE) && (s1_linv_r || s1_rinv_r)) |=> $stable(win_sum_r))
    else $error("invalid sample changed the window sum");

  a_state_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    s3_go |=> (out_v_r && (out_steer_control == steer_r)
               && (out_combined_error == last_comb_r)))
    else $error("result register and steering state disagree");

  a_s3_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !out_go) |=> s3_v_r)
    else $error("combined error dropped while output stalled");

endmodule

`default_nettype wire

[tb/tb_windowed_pid_step_steering.sv]
`default_nettype none

module tb_windowed_pid_step_steering;
  import wpss_pkg::*;

  localparam int WINDOW     = WINDOW_DEPTH_DEF;
  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 92;

  // Index past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  // Reading flags, packed as {left_invalid, left_infinite, right_invalid, right_infinite}
  localparam logic [3:0] F_NONE  = 4'b0000;
  localparam logic [3:0] F_L_INV = 4'b1000;
  localparam logic [3:0] F_L_INF = 4'b0100;
  localparam logic [3:0] F_R_INV = 4'b0010;
  localparam logic [3:0] F_R_INF = 4'b0001;

  typedef struct {
    opcode_t           op;
    logic [DIST_W-1:0] left_mm;
    logic [DIST_W-1:0] right_mm;
    logic [3:0]        flags;
  } dist_item_t;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer;
    logic signed [COMB_W-1:0]  comb;
  } steer_result_t;

  typedef struct {
    dist_item_t    item;
    bit            typed;
    steer_result_t res;
  } dir_row_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = 1'b0;
  logic [DIST_W-1:0]     in_left_mm = '0;
  logic [DIST_W-1:0]     in_right_mm = '0;
  logic                  in_left_invalid = 1'b0;
  logic                  in_left_infinite = 1'b0;
  logic                  in_right_invalid = 1'b0;
  logic                  in_right_infinite = 1'b0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [STEER_W-1:0]   out_steer_control;
  logic signed [COMB_W-1:0]    out_combined_error;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  windowed_pid_step_steering #(
    .WINDOW_DEPTH(WINDOW)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_left_mm        (in_left_mm),
    .in_right_mm       (in_right_mm),
    .in_left_invalid   (in_left_invalid),
    .in_left_infinite  (in_left_infinite),
    .in_right_invalid  (in_right_invalid),
    .in_right_infinite (in_right_infinite),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_steer_control (out_steer_control),
    .out_combined_error(out_combined_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Controller mirror: registers, error window and steering state
  longint kp = 256, ki = 0, kd = 0;
  longint band = 0, ctrl_max = 1000, ctrl_step = 50, range_lim = 30000;
  logic signed [ERR_W-1:0] err_win [WINDOW];
  longint win_sum = 0;
  longint steer_st = 0;
  longint last_comb = 0;

  steer_result_t pending_steer [$];
  dir_row_t      dir_rows [$];
  reg_write_t    reg_plan [$];
  int            burst_left [2] = '{0, 0};
  int            fail_count = 0;

  initial begin
    foreach (err_win[i]) err_win[i] = '0;
  end

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("windowed_pid_step_steering regression: fail");
    $finish;
  end

  // Register write as the block decodes it: low bits only, spare index ignored
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_GAIN_P:       kp = longint'($signed(d[GAIN_W-1:0]));
      CFG_GAIN_I:       ki = longint'($signed(d[GAIN_W-1:0]));
      CFG_GAIN_D:       kd = longint'($signed(d[GAIN_W-1:0]));
      CFG_DEAD_BAND:    band = longint'({33'd0, d[BAND_W-1:0]});
      CFG_CONTROL_MAX:  ctrl_max = longint'({49'd0, d[CTRL_W-1:0]});
      CFG_CONTROL_STEP: ctrl_step = longint'({49'd0, d[CTRL_W-1:0]});
      CFG_RANGE_LIMIT:  range_lim = longint'({48'd0, d[DIST_W-1:0]});
      default: ;
    endcase
  endfunction

  // Advance the mirror by one item; returns 1 when a tick yields a result
  function automatic bit pid_advance(input dist_item_t it, output steer_result_t res);
    longint lft, rgt, e, e0, e1, acc, c, s;
    res = '0;
    if (it.op == OP_SAMPLE) begin
      // any invalid side drops the whole sample
      if (it.flags[3] || it.flags[1]) return 1'b0;
      lft = it.flags[2] ? range_lim : longint'({48'd0, it.left_mm});
      rgt = it.flags[0] ? range_lim : longint'({48'd0, it.right_mm});
      e = lft - rgt;
      win_sum += e - longint'(err_win[WINDOW-1]);
      for (int i = WINDOW - 1; i > 0; i--) err_win[i] = err_win[i-1];
      err_win[0] = e[ERR_W-1:0];
      return 1'b0;
    end
    e0 = longint'(err_win[0]);
    e1 = longint'(err_win[1]);
    acc = kp * e0 + ki * win_sum + kd * (e0 - e1);
    c = acc >>> 8;
    if (c > COMB_HI) c = COMB_HI;
    if (c < COMB_LO) c = COMB_LO;
    s = steer_st;
    // step toward the error, restart from zero on a sign change
    if (c > band && s < ctrl_max) begin
      s = (last_comb < 0) ? 0 : s + ctrl_step;
    end else if (c < -band && s > -ctrl_max) begin
      s = (last_comb > 0) ? 0 : s - ctrl_step;
    end else if (c <= band && c >= -band) begin
      s = 0;
    end
    if (s > ctrl_max) s = ctrl_max;
    if (s < -ctrl_max) s = -ctrl_max;
    steer_st = s;
    last_comb = c;
    res.steer = s[STEER_W-1:0];
    res.comb = c[COMB_W-1:0];
    return 1'b1;
  endfunction

  // Per-transfer idle draw; side 0 is the sender, side 1 the receiver
  function automatic int draw_gap(input int side);
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic void add_row(opcode_t op, int l, int r, logic [3:0] f,
                                  bit typed, int s, int c);
    dir_row_t row;
    row.item.op = op;
    row.item.left_mm = l[DIST_W-1:0];
    row.item.right_mm = r[DIST_W-1:0];
    row.item.flags = f;
    row.typed = typed;
    row.res.steer = s[STEER_W-1:0];
    row.res.comb = c;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic dist_item_t rand_item();
    dist_item_t it;
    int base;
    it.op = ($urandom_range(0, 9) < 3) ? OP_TICK : OP_SAMPLE;
    it.flags = {$urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0,
                $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0};
    case ($urandom_range(0, 3))
      0: begin
        it.left_mm = DIST_W'($urandom);
        it.right_mm = DIST_W'($urandom);
      end
      1: begin
        it.left_mm = $urandom_range(0, 1) ? '1 : '0;
        it.right_mm = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        // close distances keep errors small, where the dead band matters
        base = $urandom_range(0, 65000);
        it.left_mm = DIST_W'(base + $urandom_range(0, 500));
        it.right_mm = DIST_W'(base + $urandom_range(0, 500));
      end
    endcase
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    int g;
    if ($urandom_range(0, 1)) return GAIN_W'($urandom);
    g = $urandom_range(0, 1024);
    g = g - 512;
    return g[GAIN_W-1:0];
  endfunction

  function automatic void push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    reg_write_t w;
    w.idx = idx;
    w.data = d;
    reg_plan.insert(reg_plan.size(), w);
  endfunction

  // Register set for one phase: two extreme corners, then random settings
  function automatic void plan_regs(input int phase);
    logic [GAIN_W-1:0] gp, gi, gd;
    logic [BAND_W-1:0] db;
    logic [CTRL_W-1:0] cm, cs;
    logic [DIST_W-1:0] rl;
    logic [31:0]       hi;
    if (phase == 0) begin
      gp = 16'h7FFF; gi = 16'h7FFF; gd = 16'h7FFF;
      db = '0; cm = '1; cs = '1; rl = '1;
    end else if (phase == 1) begin
      gp = 16'h8000; gi = 16'h8000; gd = 16'h8000;
      db = '1; cm = '0; cs = '0; rl = '0;
    end else begin
      gp = rand_gain(); gi = rand_gain(); gd = rand_gain();
      db = BAND_W'($urandom >> $urandom_range(1, 31));
      cm = CTRL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                               : $urandom_range(0, 2000));
      cs = CTRL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                               : $urandom_range(0, 300));
      rl = DIST_W'($urandom);
    end
    hi = $urandom;
    push_reg(CFG_IDX_SPARE, $urandom);
    push_reg(CFG_GAIN_P, {hi[15:0], gp});
    push_reg(CFG_GAIN_I, {hi[31:16], gi});
    push_reg(CFG_GAIN_D, {hi[23:8], gd});
    push_reg(CFG_DEAD_BAND, {hi[5], db});
    push_reg(CFG_CONTROL_MAX, {hi[16:0], cm});
    push_reg(CFG_CONTROL_STEP, {hi[31:15], cs});
    push_reg(CFG_RANGE_LIMIT, {hi[19:4], rl});
  endfunction

  task automatic write_regs();
    foreach (reg_plan[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_plan[i].idx;
      cfg_data <= reg_plan[i].data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(reg_plan[i].idx, reg_plan[i].data);
    end
    cfg_valid <= 1'b0;
    reg_plan.delete();
  endtask

  // One input transfer; the mirror advances at the accepting edge
  task automatic send_item(input dist_item_t it, input bit typed, input steer_result_t want);
    int gap;
    steer_result_t res;
    gap = draw_gap(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= it.op;
    in_left_mm <= it.left_mm;
    in_right_mm <= it.right_mm;
    {in_left_invalid, in_left_infinite, in_right_invalid, in_right_infinite} <= it.flags;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (pid_advance(it, res)) pending_steer.insert(pending_steer.size(), typed ? want : res);
  endtask

  // Wait out outstanding results, then the pipeline tail that samples leave behind
  task automatic drain();
    int k;
    k = 0;
    while (pending_steer.size() != 0 && k < 2000) begin
      @(posedge clk);
      k++;
    end
    if (pending_steer.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_steer.size());
      fail_count += pending_steer.size();
      pending_steer.delete();
    end
    repeat (10) @(posedge clk);
  endtask

  // Receiver: random stall, possibly none, ahead of every result transfer
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(1);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result check against the oldest outstanding expectation
  always @(posedge clk) begin
    steer_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_steer.size() == 0) begin
        $display("%0t: unexpected result steer_control %0d combined_error %0d",
                 $time, out_steer_control, out_combined_error);
        fail_count++;
      end else begin
        want = pending_steer.pop_front();
        if (out_steer_control !== want.steer) begin
          $display("%0t: steer_control expected %0d got %0d",
                   $time, want.steer, out_steer_control);
          fail_count++;
        end
        if (out_combined_error !== want.comb) begin
          $display("%0t: combined_error expected %0d got %0d",
                   $time, want.comb, out_combined_error);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    dist_item_t it;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass on reset settings: gain_p of one makes combined equal the error
    add_row(OP_TICK,   0,     0,     F_NONE,  1, 0,    0);
    add_row(OP_SAMPLE, 65535, 0,     F_NONE,  0, 0,    0);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, 50,   65535);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, 100,  65535);
    add_row(OP_SAMPLE, 0,     65535, F_NONE,  0, 0,    0);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, 0,    -65535);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, -50,  -65535);
    add_row(OP_SAMPLE, 5,     0,     F_L_INV, 0, 0,    0);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, -100, -65535);
    add_row(OP_SAMPLE, 7,     9,     F_R_INV | F_R_INF, 0, 0, 0);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, -150, -65535);
    add_row(OP_SAMPLE, 123,   1000,  F_L_INF, 0, 0,    0);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, 0,    29000);
    add_row(OP_SAMPLE, 0,     456,   F_R_INF, 0, 0,    0);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, 0,    -30000);
    add_row(OP_SAMPLE, 65535, 65535, F_L_INF | F_R_INF, 0, 0, 0);
    add_row(OP_TICK,   0,     0,     F_NONE,  1, 0,    0);
    add_row(OP_SAMPLE, 65535, 0,     F_L_INV | F_L_INF | F_R_INV | F_R_INF, 0, 0, 0);
    add_row(OP_TICK,   65535, 65535, F_L_INV | F_L_INF | F_R_INV | F_R_INF, 1, 0, 0);
    add_row(OP_SAMPLE, 300,   100,   F_NONE,  0, 0,    0);
    add_row(OP_SAMPLE, 100,   400,   F_NONE,  0, 0,    0);
    add_row(OP_TICK,   0,     0,     F_NONE,  0, 0,    0);
    add_row(OP_TICK,   0,     0,     F_NONE,  0, 0,    0);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    in_valid <= 1'b0;
    drain();

    // Random phases, each under its own register set
    for (int p = 0; p < N_PHASES; p++) begin
      plan_regs(p);
      write_regs();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = rand_item();
        send_item(it, 1'b0, '0);
      end
      in_valid <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("windowed_pid_step_steering regression: pass");
    end else begin
      $display("windowed_pid_step_steering regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
